@@ design/qgi_pkg.sv @@
// Package of the quaternion gyro integrator: sequencer states and fixed constants.
`default_nettype none
package qgi_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DMUL,
		ST_DACC,
		ST_IMUL,
		ST_IDIV0,
		ST_IDIV,
		ST_IADD,
		ST_SMUL,
		ST_SACC,
		ST_SQRT,
		ST_NDIV0,
		ST_NDIV,
		ST_NFIN,
		ST_DONE
	} qgi_state_t;

	typedef enum logic [1:0] {
		OP_INTEGRATE = 2'd0,
		OP_IDENTITY  = 2'd1,
		OP_LAUNCH    = 2'd2,
		OP_NONE      = 2'd3
	} qgi_op_t;

	localparam int unsigned NUM_CFG = 7;
	localparam logic [2:0] CFG_BIAS_X = 3'd0;
	localparam logic [2:0] CFG_BIAS_Y = 3'd1;
	localparam logic [2:0] CFG_BIAS_Z = 3'd2;
	localparam logic [2:0] CFG_LAUNCH_W = 3'd3;
	localparam logic signed [31:0] Q_ONE = 32'sd1073741824;
	localparam logic signed [31:0] SAT_MAX = 32'sd2147483647;
	localparam logic [31:0] STEP_DEN = 32'd15625;
	localparam logic [63:0] STEP_HALF = 64'd7812;
	// Digits below 15625 * 2^16 divide exactly by this reciprocal scaled by 2^44.
	localparam logic signed [31:0] STEP_RECIP = 32'sd1125899907;
	localparam int unsigned STEP_SHIFT = 44;
	localparam int unsigned STEP_CHUNKS = 4;
	localparam int unsigned DIV_STEPS = 62;
	localparam int unsigned SQRT_STEPS = 32;

	function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v > 35'sd2147483647) r = 32'sh7fffffff;
		else if (v < -35'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/quaternion_gyro_integrator_top.sv @@
// Top level of the quaternion gyro integrator with its sequencer and shared arithmetic.
//
// Input beats arrive on s_tvalid/s_tready: s_tuser carries the operation, s_tdata the
// three raw Q16.16 rates and the time step in microseconds. Each beat gives exactly one
// output beat on m_tvalid/m_tready with the Q2.30 orientation and the Q16.16 derivative.
// Configuration is to be written through cfg_we/cfg_index/cfg_data while the block is
// idle; the block itself does not enforce this. An integrate beat runs the twelve
// derivative products on the shared 32x32 multiplier, the four step increments, each
// a reciprocal multiplication over four 16-bit digits, the four squares, the bit-serial
// square root and the four normalizing divisions through the 62-step restoring
// divider, then loads the output register. A zero norm skips the divisions. Identity,
// launch and no-op beats go straight to the final step. The next beat is taken in the
// cycle after the result is loaded.
// s_tready is high only while the sequencer is idle. The result sits in an output
// register, so a new beat is taken while the previous result still waits; a stalled
// receiver holds the sequencer at its final step until the register frees.
// Reset clears the configuration to zero bias and identity launch orientation,
// sets the orientation to identity and drops m_tvalid.
`default_nettype none
module quaternion_gyro_integrator_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// raw_rate_z[31:0], raw_rate_y[63:32], raw_rate_x[95:64], step_us[115:96], zero fill
	input  wire logic [119:0] s_tdata,
	// operation[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// quat_w, quat_x, quat_y, quat_z, deriv_w, deriv_x, deriv_y, deriv_z, 32 bits each
	output logic [255:0]      m_tdata,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import qgi_pkg::*;

	qgi_state_t state_q, state_n;

	logic signed [31:0] cfg_q    [NUM_CFG];
	logic signed [31:0] orient_q [4];
	logic signed [31:0] deriv_q  [4];
	logic signed [31:0] sum_q    [4];
	logic signed [31:0] rate_q   [3];
	logic [19:0]        dt_q;
	logic [1:0]         comp_q;
	logic [1:0]         term_q;
	logic [5:0]         cnt_q;
	logic signed [65:0] acc_q;
	logic signed [63:0] prod_q;
	logic [31:0]        div_den_q;
	logic [31:0]        div_rem_q;
	logic [61:0]        div_quo_q;
	logic               div_neg_q;
	logic [63:0]        inum_q;
	logic [15:0]        iqd_q;
	logic [63:0]        sq_q;
	logic [63:0]        res_q;
	logic [63:0]        bit_q;
	logic [255:0]       m_tdata_q;
	logic               m_tvalid_q;

	logic signed [31:0] mul_a, mul_b;
	logic               mul_neg;
	logic signed [65:0] acc_n;
	logic signed [65:0] acc_rnd;
	logic [32:0]        div_t, div_diff;
	logic               div_ge;
	logic [29:0]        idiv_v;
	logic [13:0]        idiv_r;
	logic [63:0]        sqrt_trial;
	logic               in_fire, out_load;
	logic signed [34:0] wx_raw, wy_raw, wz_raw;
	logic [63:0]        prod_abs;
	logic signed [63:0] inc64, sum64;
	logic [30:0]        s_abs;
	logic [62:0]        quo_ext;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign wx_raw = 35'(signed'(s_tdata[95:64])) - 35'(cfg_q[CFG_BIAS_X]);
	assign wy_raw = 35'(signed'(s_tdata[63:32])) - 35'(cfg_q[CFG_BIAS_Y]);
	assign wz_raw = -35'(signed'(s_tdata[31:0])) - 35'(cfg_q[CFG_BIAS_Z]);

	assign idiv_v = {div_rem_q[13:0], inum_q[63:48]};
	assign idiv_r = 14'(idiv_v - prod_q[29:0]);

	always_comb begin
		mul_a = rate_q[0];
		mul_b = orient_q[1];
		mul_neg = 1'b0;
		case (state_q)
			ST_DMUL, ST_DACC: begin
				case ({comp_q, term_q})
					4'h0: begin mul_a = rate_q[0]; mul_b = orient_q[1]; mul_neg = 1'b1; end
					4'h1: begin mul_a = rate_q[1]; mul_b = orient_q[2]; mul_neg = 1'b1; end
					4'h2: begin mul_a = rate_q[2]; mul_b = orient_q[3]; mul_neg = 1'b1; end
					4'h4: begin mul_a = rate_q[0]; mul_b = orient_q[0]; mul_neg = 1'b0; end
					4'h5: begin mul_a = rate_q[2]; mul_b = orient_q[2]; mul_neg = 1'b0; end
					4'h6: begin mul_a = rate_q[1]; mul_b = orient_q[3]; mul_neg = 1'b1; end
					4'h8: begin mul_a = rate_q[1]; mul_b = orient_q[0]; mul_neg = 1'b0; end
					4'h9: begin mul_a = rate_q[2]; mul_b = orient_q[1]; mul_neg = 1'b1; end
					4'ha: begin mul_a = rate_q[0]; mul_b = orient_q[3]; mul_neg = 1'b0; end
					4'hc: begin mul_a = rate_q[2]; mul_b = orient_q[0]; mul_neg = 1'b0; end
					4'hd: begin mul_a = rate_q[1]; mul_b = orient_q[1]; mul_neg = 1'b0; end
					4'he: begin mul_a = rate_q[0]; mul_b = orient_q[2]; mul_neg = 1'b1; end
					default: begin mul_a = rate_q[0]; mul_b = orient_q[1]; mul_neg = 1'b0; end
				endcase
			end
			ST_IMUL: begin
				mul_a = deriv_q[comp_q];
				mul_b = signed'({12'd0, dt_q});
			end
			ST_IDIV: begin
				if (term_q == 2'd0) begin
					mul_a = signed'({2'b00, idiv_v});
					mul_b = STEP_RECIP;
				end else begin
					mul_a = signed'({16'd0, prod_q[STEP_SHIFT +: 16]});
					mul_b = signed'(STEP_DEN);
				end
			end
			ST_SMUL: begin
				mul_a = sum_q[comp_q];
				mul_b = sum_q[comp_q];
			end
			default: begin
				mul_a = rate_q[0];
				mul_b = orient_q[1];
			end
		endcase
	end

	assign acc_n = mul_neg ? (acc_q - 66'(prod_q)) : (acc_q + 66'(prod_q));
	assign acc_rnd = acc_n + 66'sd1073741824;

	assign div_t = {div_rem_q, div_quo_q[61]};
	assign div_diff = div_t - {1'b0, div_den_q};
	assign div_ge = (div_t >= {1'b0, div_den_q});

	assign sqrt_trial = res_q + bit_q;

	assign prod_abs = prod_q[63] ? (64'd0 - 64'(prod_q)) : 64'(prod_q);
	assign quo_ext = {1'b0, div_quo_q};
	assign inc64 = div_neg_q ? -signed'(inum_q) : signed'(inum_q);
	assign sum64 = 64'(orient_q[comp_q]) + inc64;
	assign s_abs = sum_q[comp_q][31] ? 31'(-sum_q[comp_q]) : sum_q[comp_q][30:0];

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (qgi_op_t'(s_tuser) == OP_INTEGRATE) state_n = ST_DMUL;
					else state_n = ST_DONE;
				end
			end
			ST_DMUL: state_n = ST_DACC;
			ST_DACC: begin
				if (term_q == 2'd2 && comp_q == 2'd3) state_n = ST_IMUL;
				else state_n = ST_DMUL;
			end
			ST_IMUL: state_n = ST_IDIV0;
			ST_IDIV0: state_n = ST_IDIV;
			ST_IDIV: begin
				if (term_q == 2'd2 && cnt_q == 6'(STEP_CHUNKS - 1)) state_n = ST_IADD;
			end
			ST_IADD: begin
				if (comp_q == 2'd3) state_n = ST_SMUL;
				else state_n = ST_IMUL;
			end
			ST_SMUL: state_n = ST_SACC;
			ST_SACC: begin
				if (comp_q == 2'd3) state_n = ST_SQRT;
				else state_n = ST_SMUL;
			end
			ST_SQRT: begin
				if (cnt_q == 6'(SQRT_STEPS - 1)) state_n = ST_NDIV0;
			end
			ST_NDIV0: begin
				if (res_q == 64'd0) state_n = ST_DONE;
				else state_n = ST_NDIV;
			end
			ST_NDIV: begin
				if (cnt_q == 6'(DIV_STEPS - 1)) state_n = ST_NFIN;
			end
			ST_NFIN: begin
				if (comp_q == 2'd3) state_n = ST_DONE;
				else state_n = ST_NDIV0;
			end
			ST_DONE: begin
				if (out_load) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++)
				cfg_q[i] <= (i == int'(CFG_LAUNCH_W)) ? Q_ONE : '0;
		end else if (cfg_we && cfg_index < 3'(NUM_CFG)) begin
			cfg_q[cfg_index] <= signed'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q[0] <= Q_ONE;
			orient_q[1] <= '0;
			orient_q[2] <= '0;
			orient_q[3] <= '0;
			m_tvalid_q <= 1'b0;
			comp_q <= '0;
			term_q <= '0;
			cnt_q <= '0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q <= {deriv_q[3], deriv_q[2], deriv_q[1], deriv_q[0],
					orient_q[3], orient_q[2], orient_q[1], orient_q[0]};
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						rate_q[0] <= sat35(wx_raw);
						rate_q[1] <= sat35(wy_raw);
						rate_q[2] <= sat35(wz_raw);
						dt_q <= s_tdata[115:96];
						for (int i = 0; i < 4; i++) deriv_q[i] <= '0;
						comp_q <= '0;
						term_q <= '0;
						acc_q <= '0;
						case (qgi_op_t'(s_tuser))
							OP_IDENTITY: begin
								orient_q[0] <= Q_ONE;
								orient_q[1] <= '0;
								orient_q[2] <= '0;
								orient_q[3] <= '0;
							end
							OP_LAUNCH: begin
								for (int i = 0; i < 4; i++)
									orient_q[i] <= cfg_q[CFG_LAUNCH_W + 3'(i)];
							end
							default: begin
							end
						endcase
					end
				end
				ST_DMUL, ST_IMUL, ST_SMUL: begin
					prod_q <= mul_a * mul_b;
				end
				ST_DACC: begin
					if (term_q == 2'd2) begin
						deriv_q[comp_q] <= sat35(acc_rnd[65:31]);
						acc_q <= '0;
						term_q <= '0;
						comp_q <= comp_q + 2'd1;
					end else begin
						acc_q <= acc_n;
						term_q <= term_q + 2'd1;
					end
				end
				ST_IDIV0: begin
					div_rem_q <= '0;
					inum_q <= {2'b00, prod_abs[53:0], 8'd0} + STEP_HALF;
					div_neg_q <= prod_q[63];
					cnt_q <= '0;
				end
				ST_IDIV: begin
					case (term_q)
						2'd0: begin
							prod_q <= mul_a * mul_b;
							term_q <= 2'd1;
						end
						2'd1: begin
							prod_q <= mul_a * mul_b;
							iqd_q <= prod_q[STEP_SHIFT +: 16];
							term_q <= 2'd2;
						end
						default: begin
							div_rem_q <= {18'd0, idiv_r};
							inum_q <= {inum_q[47:0], iqd_q};
							cnt_q <= cnt_q + 6'd1;
							term_q <= 2'd0;
						end
					endcase
				end
				ST_NDIV: begin
					div_rem_q <= div_ge ? div_diff[31:0] : div_t[31:0];
					div_quo_q <= {div_quo_q[60:0], div_ge};
					cnt_q <= cnt_q + 6'd1;
				end
				ST_IADD: begin
					if (sum64 > 64'(SAT_MAX)) sum_q[comp_q] <= SAT_MAX;
					else if (sum64 < -64'(SAT_MAX)) sum_q[comp_q] <= -SAT_MAX;
					else sum_q[comp_q] <= sum64[31:0];
					comp_q <= comp_q + 2'd1;
					acc_q <= '0;
				end
				ST_SACC: begin
					acc_q <= acc_n;
					comp_q <= comp_q + 2'd1;
					if (comp_q == 2'd3) begin
						sq_q <= acc_n[63:0];
						res_q <= '0;
						bit_q <= 64'h4000_0000_0000_0000;
						cnt_q <= '0;
					end
				end
				ST_SQRT: begin
					if (sq_q >= sqrt_trial) begin
						sq_q <= sq_q - sqrt_trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + 6'd1;
				end
				ST_NDIV0: begin
					if (res_q == 64'd0) begin
						orient_q[0] <= Q_ONE;
						orient_q[1] <= '0;
						orient_q[2] <= '0;
						orient_q[3] <= '0;
					end
					div_den_q <= res_q[31:0];
					div_rem_q <= '0;
					div_quo_q <= {1'b0, s_abs, 30'd0} + {31'd0, res_q[31:1]};
					div_neg_q <= sum_q[comp_q][31];
					cnt_q <= '0;
				end
				ST_NFIN: begin
					if (!div_neg_q && quo_ext > 63'h7fff_ffff)
						orient_q[comp_q] <= 32'sh7fffffff;
					else if (div_neg_q && quo_ext > 63'h8000_0000)
						orient_q[comp_q] <= 32'sh80000000;
					else if (div_neg_q)
						orient_q[comp_q] <= 32'(-signed'(quo_ext));
					else
						orient_q[comp_q] <= div_quo_q[31:0];
					comp_q <= comp_q + 2'd1;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire
